// File: src/hcbd_pkg.sv
package hcbd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;
  localparam int unsigned TOTAL_BITS    = 32;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_DONE     = 3'd1,
    ST_NO_DIGIT = 3'd2,
    ST_BAD_END  = 3'd3,
    ST_EARLY    = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_DIGITS = 7'b0000010,
    PH_SKIP   = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_END_CR = 7'b0010000,
    PH_END_LF = 7'b0100000,
    PH_STOP   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]            payload_byte;
    logic                  payload_valid;
    status_e               status;
    logic [TOTAL_BITS-1:0] payload_total;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: src/hcbd_stream_if.sv
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [2:0]  status;
  logic [31:0] payload_total;

  modport source (output valid, output payload_byte, output payload_valid,
                  output status, output payload_total, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input status, input payload_total, output ready);
endinterface

// File: src/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder. Feed the body one byte per item and flag its
// final byte with last_byte; every input item yields exactly one result item
// carrying the payload byte (zero unless payload_valid), the status (running,
// done, or a sticky error code) and the saturating count of payload bytes so
// far. The block takes one item per clock as long as the result side keeps
// taking them: the byte sits in an input register, the decode logic updates
// the chunk state and fills the result register, and the result item is
// presented from that register.
// After the last byte all decode state returns to the start of a new body.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_ch_i,
  hcbd_out_if.source out_ch_o
);
  import hcbd_pkg::*;

  logic    stage_valid;
  item_t   stage_item;
  logic    out_can_load;
  logic    step;
  result_t step_result;

  // Advance the decoder whenever a byte is held and the result slot is free.
  assign step = stage_valid && out_can_load;

  // Hold the accepted byte until the decoder consumes it.
  hcbd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch_i),
    .take_i  (step),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  // Chunk-framing state and the per-byte decode.
  hcbd_decoder #(
    .SIZE_BITS (SIZE_BITS)
  ) u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (stage_item),
    .result_o (step_result)
  );

  // Result register toward the sink.
  hcbd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .result_i   (step_result),
    .can_load_o (out_can_load),
    .out_ch_o   (out_ch_o)
  );

  // A waiting result must never be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && !out_ch_o.ready) |-> !step)
    else $error("result overwritten while stalled");

  // Input backpressure only when a byte is held and cannot move on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch_i.ready |-> (stage_valid && !out_can_load))
    else $error("input stalled without cause");

  // A result without payload carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && !out_ch_o.payload_valid) |-> (out_ch_o.payload_byte == 8'd0))
    else $error("stray payload byte");
endmodule

// File: src/hcbd_in_stage.sv
module hcbd_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  hcbd_in_if.sink       in_ch_i,
  input  logic          take_i,
  output logic          valid_o,
  output hcbd_pkg::item_t item_o
);
  import hcbd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  // Refill whenever the held item leaves this cycle or the stage is empty.
  assign in_ch_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_ch_i.ready) begin
      valid_d = in_ch_i.valid;
      item_d  = '{byte_in: in_ch_i.byte_in, last_byte: in_ch_i.last_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// File: src/hcbd_decoder.sv
module hcbd_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  hcbd_pkg::item_t   item_i,
  output hcbd_pkg::result_t result_o
);
  import hcbd_pkg::*;

  phase_e                phase_q, phase_d;
  logic [SIZE_BITS-1:0]  chunk_size_q, chunk_size_d;
  logic [SIZE_BITS-1:0]  bytes_left_q, bytes_left_d;
  logic                  saw_cr_q, saw_cr_d;
  logic [TOTAL_BITS-1:0] total_q, total_d;
  status_e               status_q, status_d;

  hex_t                  hex;
  logic [SIZE_BITS-1:0]  left_dec;
  logic                  data_beat;

  assign hex      = hex_decode(item_i.byte_in);
  assign left_dec = bytes_left_q - SIZE_BITS'(1);

  always_comb begin
    phase_d      = phase_q;
    chunk_size_d = chunk_size_q;
    bytes_left_d = bytes_left_q;
    saw_cr_d     = saw_cr_q;
    total_d      = total_q;
    status_d     = status_q;
    data_beat    = 1'b0;

    unique case (phase_q)
      PH_START: begin
        if (!hex.ok) begin
          phase_d  = PH_STOP;
          status_d = ST_NO_DIGIT;
        end else begin
          chunk_size_d = SIZE_BITS'(hex.val);
          phase_d      = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (hex.ok) begin
          if (chunk_size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_d  = PH_STOP;
            status_d = ST_OVERFLOW;
          end else begin
            chunk_size_d = {chunk_size_q[SIZE_BITS-5:0], hex.val};
          end
        end else if (chunk_size_q == '0) begin
          phase_d  = PH_STOP;
          status_d = ST_DONE;
        end else begin
          bytes_left_d = chunk_size_q;
          saw_cr_d     = (item_i.byte_in == CH_CR);
          phase_d      = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (saw_cr_q && item_i.byte_in == CH_LF) begin
          saw_cr_d = 1'b0;
          phase_d  = PH_DATA;
        end else begin
          saw_cr_d = (item_i.byte_in == CH_CR);
        end
      end
      PH_DATA: begin
        data_beat    = 1'b1;
        total_d      = (total_q != '1) ? total_q + TOTAL_BITS'(1) : total_q;
        bytes_left_d = left_dec;
        if (left_dec == '0) phase_d = PH_END_CR;
      end
      PH_END_CR: begin
        if (item_i.byte_in == CH_CR) begin
          phase_d = PH_END_LF;
        end else begin
          phase_d  = PH_STOP;
          status_d = ST_BAD_END;
        end
      end
      PH_END_LF: begin
        if (item_i.byte_in == CH_LF) begin
          phase_d = PH_START;
        end else begin
          phase_d  = PH_STOP;
          status_d = ST_BAD_END;
        end
      end
      PH_STOP: begin
      end
      default: begin
        phase_d = PH_STOP;
      end
    endcase

    // Close out the body on its last byte.
    if (item_i.last_byte) begin
      if (phase_d == PH_DIGITS && chunk_size_d == '0) begin
        phase_d  = PH_STOP;
        status_d = ST_DONE;
      end
      if (phase_d != PH_STOP) begin
        phase_d  = PH_STOP;
        status_d = ST_EARLY;
      end
    end

    result_o.payload_byte  = data_beat ? item_i.byte_in : 8'd0;
    result_o.payload_valid = data_beat;
    result_o.status        = status_d;
    result_o.payload_total = total_d;

    if (item_i.last_byte) begin
      phase_d      = PH_START;
      chunk_size_d = '0;
      bytes_left_d = '0;
      saw_cr_d     = 1'b0;
      total_d      = '0;
      status_d     = ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      chunk_size_q <= '0;
      bytes_left_q <= '0;
      saw_cr_q     <= 1'b0;
      total_q      <= '0;
      status_q     <= ST_RUN;
    end else if (step_i) begin
      phase_q      <= phase_d;
      chunk_size_q <= chunk_size_d;
      bytes_left_q <= bytes_left_d;
      saw_cr_q     <= saw_cr_d;
      total_q      <= total_d;
      status_q     <= status_d;
    end
  end
endmodule

// File: src/hcbd_out_stage.sv
module hcbd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hcbd_pkg::result_t result_i,
  output logic              can_load_o,
  hcbd_out_if.source        out_ch_o
);
  import hcbd_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign can_load_o = !valid_q || out_ch_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) result_q <= result_i;
  end

  assign out_ch_o.valid         = valid_q;
  assign out_ch_o.payload_byte  = result_q.payload_byte;
  assign out_ch_o.payload_valid = result_q.payload_valid;
  assign out_ch_o.status        = result_q.status;
  assign out_ch_o.payload_total = result_q.payload_total;
endmodule

// File: tb/tb_http_chunked_body_decoder.sv
module tb_http_chunked_body_decoder;
  import hcbd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 2000;

  logic clk_i;
  logic rst_ni;

  hcbd_in_if  in_ch ();
  hcbd_out_if out_ch ();

  http_chunked_body_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  // Decoder state as this bench predicts it.
  phase_e      dec_phase;
  logic [31:0] dec_size;
  logic [31:0] dec_left;
  logic        dec_cr_seen;
  logic [31:0] dec_total;
  status_e     dec_status;

  result_t     decoded_q[$];   // expected result items, oldest first
  logic [7:0]  body_q[$];      // bytes of the body being sent

  int  err_count;
  int  cycle_count;
  int  live_items;             // items that reached the decoder before it stopped
  int  bytes_in;
  int  payload_out;
  int  body_count;
  int  end_hits[8];            // how each body ended, by status code
  bit  src_steady;
  bit  sink_steady;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, decoded_q.size());
      $display("FAIL http_chunked_body_decoder");
      $finish;
    end
  end

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int hex_nibble_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // Pick either letter case for digits above nine.
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void decode_clear();
    dec_phase   = PH_START;
    dec_size    = '0;
    dec_left    = '0;
    dec_cr_seen = 1'b0;
    dec_total   = '0;
    dec_status  = ST_RUN;
  endfunction

  function automatic void decode_halt(status_e code);
    dec_status = code;
    dec_phase  = PH_STOP;
  endfunction

  // Advance the predicted decoder by one byte and return the result item.
  function automatic result_t decode_step(logic [7:0] b, logic last);
    result_t r;
    int      d;
    logic    pass;
    d    = hex_nibble_value(b);
    pass = 1'b0;
    case (dec_phase)
      PH_START: begin
        if (d < 0) begin
          decode_halt(ST_NO_DIGIT);
        end else begin
          dec_size  = d;
          dec_phase = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (d >= 0) begin
          // A set bit in the top nibble would be shifted out.
          if (dec_size[31:28] != 4'd0) decode_halt(ST_OVERFLOW);
          else dec_size = {dec_size[27:0], d[3:0]};
        end else if (dec_size == '0) begin
          decode_halt(ST_DONE);
        end else begin
          // The byte that ends the digits is the first skipped one.
          dec_left    = dec_size;
          dec_cr_seen = (b == CH_CR);
          dec_phase   = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (dec_cr_seen && b == CH_LF) begin
          dec_cr_seen = 1'b0;
          dec_phase   = PH_DATA;
        end else begin
          dec_cr_seen = (b == CH_CR);
        end
      end
      PH_DATA: begin
        pass = 1'b1;
        if (dec_total != '1) dec_total++;
        dec_left--;
        if (dec_left == '0) dec_phase = PH_END_CR;
      end
      PH_END_CR: begin
        if (b == CH_CR) dec_phase = PH_END_LF;
        else decode_halt(ST_BAD_END);
      end
      PH_END_LF: begin
        if (b == CH_LF) dec_phase = PH_START;
        else decode_halt(ST_BAD_END);
      end
      default: ;
    endcase
    // A last byte can finish a zero size; otherwise it ends the body early.
    if (last && dec_phase == PH_DIGITS && dec_size == '0) decode_halt(ST_DONE);
    if (last && dec_phase != PH_STOP) decode_halt(ST_EARLY);
    r.payload_byte  = pass ? b : 8'h00;
    r.payload_valid = pass;
    r.status        = dec_status;
    r.payload_total = dec_total;
    if (last) begin
      end_hits[dec_status]++;
      body_count++;
      decode_clear();
    end
    return r;
  endfunction

  // Offer one item, hold it until the decoder takes it, then predict its result.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = src_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.byte_in   <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    if (dec_phase != PH_STOP) live_items++;
    bytes_in++;
    decoded_q.push_back(decode_step(b, last));
  endtask

  task automatic send_body();
    foreach (body_q[i]) send_byte(body_q[i], i == body_q.size() - 1);
  endtask

  task automatic wait_drained();
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side: mostly ready, with short and occasional long stalls.
  initial begin : sink_pacing
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_steady) begin
        out_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        hold = idle_len();
        out_ch.ready <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected: byte %02h valid %0d status %0d total %0d",
                 $time, out_ch.payload_byte, out_ch.payload_valid, out_ch.status,
                 out_ch.payload_total);
      end else begin
        want = decoded_q.pop_front();
        if (want.payload_valid) payload_out++;
        if (out_ch.payload_byte !== want.payload_byte) begin
          err_count++;
          $display("%0t: payload_byte expected %02h got %02h",
                   $time, want.payload_byte, out_ch.payload_byte);
        end
        if (out_ch.payload_valid !== want.payload_valid) begin
          err_count++;
          $display("%0t: payload_valid expected %0d got %0d",
                   $time, want.payload_valid, out_ch.payload_valid);
        end
        if (out_ch.status !== want.status) begin
          err_count++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_ch.status);
        end
        if (out_ch.payload_total !== want.payload_total) begin
          err_count++;
          $display("%0t: payload_total expected %0d got %0d",
                   $time, want.payload_total, out_ch.payload_total);
        end
      end
    end
  end

  // A body that opens with a non-hex byte fails at once.
  task automatic test_no_digit();
    body_q = '{8'hFF};
    send_body();
  endtask

  // Zero size closed by the last byte, then by a CR with trailing junk ignored.
  task automatic test_zero_size();
    body_q = '{8'h30};
    send_body();
    body_q = '{8'h30, CH_CR, 8'h00, 8'h58};
    send_body();
  endtask

  // Lone LF and lone CR in the skip; early end on the closing LF and on payload.
  task automatic test_extension_skip();
    body_q = '{8'h31, CH_LF, CH_CR, CH_LF, 8'hFF, CH_CR, CH_LF};
    send_body();
    body_q = '{8'h31, CH_CR, CH_CR, CH_LF, 8'h00};
    send_body();
  endtask

  // Nine digits with a set top nibble; overflow wins over the early end.
  task automatic test_size_overflow();
    body_q = '{8'h46, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h61};
    send_body();
  endtask

  // Append a chunk header: hex size with optional leading zeros, optional extension, CR LF.
  task automatic push_header(int unsigned size);
    int top;
    repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0) body_q.push_back(8'h30);
    top = 0;
    for (int i = 7; i > 0; i--) if (size[4*i +: 4] != 4'd0 && top == 0) top = i;
    for (int i = top; i >= 0; i--) body_q.push_back(hex_char(size[4*i +: 4]));
    if ($urandom_range(0, 9) < 3) begin
      body_q.push_back(8'h3B);
      repeat ($urandom_range(0, 5)) body_q.push_back(8'($urandom_range(0, 255)));
    end
    body_q.push_back(CH_CR);
    body_q.push_back(CH_LF);
  endtask

  // Build one random body: mostly well formed, some noise, some damaged.
  task automatic build_body();
    int          kind;
    int unsigned size;
    body_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      if (kind < 12) begin
        // Oversized size: nine or ten digits led by a nonzero one.
        body_q.push_back(hex_char($urandom_range(1, 15)));
        repeat ($urandom_range(8, 9)) body_q.push_back(hex_char($urandom_range(0, 15)));
        body_q.push_back(CH_CR);
        body_q.push_back(CH_LF);
      end else begin
        size = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
        push_header(size);
        repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
        body_q.push_back(CH_CR);
        body_q.push_back(CH_LF);
      end
    end
    push_header(0);
    if ($urandom_range(0, 1)) begin
      body_q.push_back(CH_CR);
      body_q.push_back(CH_LF);
    end
    if ($urandom_range(0, 9) == 0) body_q.push_back(8'($urandom_range(0, 255)));
    // Damage a byte or cut the body short.
    if ($urandom_range(0, 99) < 15)
      body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 10) begin
      size = $urandom_range(1, body_q.size());
      while (body_q.size() > size) void'(body_q.pop_back());
    end
  endtask

  task automatic test_random_bodies();
    int start;
    start = live_items;
    while (live_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) src_steady = ~src_steady;
      if ($urandom_range(0, 9) == 0) sink_steady = ~sink_steady;
      build_body();
      send_body();
      // Hold off now and then until every result is back.
      if ($urandom_range(0, 19) == 0) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    err_count       = 0;
    cycle_count     = 0;
    live_items      = 0;
    bytes_in        = 0;
    payload_out     = 0;
    body_count      = 0;
    src_steady      = 1'b0;
    sink_steady     = 1'b0;
    foreach (end_hits[i]) end_hits[i] = 0;
    decode_clear();
    in_ch.valid     = 1'b0;
    in_ch.byte_in   = 8'h00;
    in_ch.last_byte = 1'b0;
    rst_ni          = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_digit();
    test_zero_size();
    test_extension_skip();
    test_size_overflow();

    // Hold the source until every directed result is back.
    in_ch.valid <= 1'b0;
    wait_drained();

    test_random_bodies();

    // Drop valid, let the pipeline empty, then watch for stray results.
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d bodies, %0d bytes in, %0d payload bytes out.",
             body_count, bytes_in, payload_out);
    $display("Body endings: done %0d, no size digit %0d, bad end %0d, early %0d, overflow %0d.",
             end_hits[ST_DONE], end_hits[ST_NO_DIGIT], end_hits[ST_BAD_END],
             end_hits[ST_EARLY], end_hits[ST_OVERFLOW]);
    if (err_count == 0) begin
      $display("PASS http_chunked_body_decoder");
    end else begin
      $display("FAIL http_chunked_body_decoder");
    end
    $finish;
  end

endmodule

// File: sim.f
src/hcbd_pkg.sv
src/hcbd_stream_if.sv
src/hcbd_in_stage.sv
src/hcbd_decoder.sv
src/hcbd_out_stage.sv
src/http_chunked_body_decoder.sv
tb/tb_http_chunked_body_decoder.sv
